// ===== rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet decode for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int COUNT_BITS = 24;
  localparam int OUT_COUNT_BITS = 24;
  localparam logic [31:0] OUT_COUNT_MAX = 32'(24'hFF_FFFF);

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0]                data_byte;
    logic                      byte_valid;
    logic                      done_res;
    logic                      empty_res;
    logic [OUT_COUNT_BITS-1:0] byte_count;
  } b64d_result_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64d_sextet_t;

  function automatic b64d_sextet_t sextet_of(input logic [7:0] ch);
    b64d_sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      s.value = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.value = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B || ch == 8'h2D) begin
      s.value = 6'd62;
    end else if (ch == 8'h2F || ch == 8'h5F) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== rtl/b64d_core.sv =====
// ----------------------------------------------------------------------------
// b64d_core
// Decoder state: accumulator, pending-bit count, pad flag and byte counter.
// ----------------------------------------------------------------------------
module b64d_core import b64d_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic [7:0]   char_code,
  input  logic         last_char,
  output logic         has_result,
  output b64d_result_t result
);

  logic [11:0]           bit_accumulator;
  logic [2:0]            pending_bits;
  logic                  stopped_flag;
  logic [COUNT_BITS-1:0] decoded_total;

  logic [11:0]           bit_accumulator_next;
  logic [2:0]            pending_bits_next;
  logic                  stopped_flag_next;
  logic [COUNT_BITS-1:0] decoded_total_next;

  b64d_sextet_t sextet;
  logic         take;
  logic         have_byte;
  logic [11:0]  shifted;
  logic [31:0]  total_wide;

  always_comb begin
    sextet = sextet_of(char_code);
    take = !stopped_flag && char_code != PAD_CHAR && sextet.valid;
    shifted = {bit_accumulator[5:0], sextet.value};
    have_byte = take && pending_bits >= 3'd2;

    bit_accumulator_next = take ? shifted : bit_accumulator;
    pending_bits_next = pending_bits;
    if (take) begin
      pending_bits_next = have_byte ? pending_bits - 3'd2 : pending_bits + 3'd6;
    end
    stopped_flag_next = stopped_flag || char_code == PAD_CHAR;
    decoded_total_next = decoded_total;
    if (have_byte && decoded_total != {COUNT_BITS{1'b1}}) begin
      decoded_total_next = decoded_total + COUNT_BITS'(1);
    end

    total_wide = 32'(decoded_total_next);
    has_result = have_byte || last_char;
    result.data_byte = have_byte ? 8'(shifted >> pending_bits_next) : 8'd0;
    result.byte_valid = have_byte;
    result.done_res = last_char;
    result.empty_res = last_char && decoded_total_next == '0;
    result.byte_count = '0;
    if (last_char) begin
      result.byte_count = (total_wide > OUT_COUNT_MAX) ? OUT_COUNT_MAX[OUT_COUNT_BITS-1:0]
                                                       : total_wide[OUT_COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator <= '0;
      pending_bits <= '0;
      stopped_flag <= 1'b0;
      decoded_total <= '0;
    end else if (advance) begin
      if (last_char) begin
        bit_accumulator <= '0;
        pending_bits <= '0;
        stopped_flag <= 1'b0;
        decoded_total <= '0;
      end else begin
        bit_accumulator <= bit_accumulator_next;
        pending_bits <= pending_bits_next;
        stopped_flag <= stopped_flag_next;
        decoded_total <= decoded_total_next;
      end
    end
  end

endmodule

// ===== rtl/b64d_out_reg.sv =====
// ----------------------------------------------------------------------------
// b64d_out_reg
// Result register that holds one decoded transaction until the sink takes it.
// ----------------------------------------------------------------------------
module b64d_out_reg import b64d_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  b64d_result_t load_result,
  input  logic         tready,
  output logic         tvalid,
  output b64d_result_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_result;
    end
  end

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, one character in, at most one byte out.
// ----------------------------------------------------------------------------
// Each input transaction carries one character; standard and URL-safe alphabets
// are both decoded and other characters are skipped. The first '=' stops
// decoding until the transaction marked by tlast, which always produces an
// output transaction with tlast set, the byte count and the empty flag, and
// then restarts the decoder for the next text. A character passes through an
// input register and one stage of decode logic into the result register, so
// the block sustains one character per cycle, and throughput drops only while
// the sink holds tready low with a result waiting.
// ----------------------------------------------------------------------------
module base64_stream_decoder import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] data_byte, [31:8] byte_count
  output logic [1:0]  m_tuser,   // [0] byte_valid, [1] empty_res
  output logic        m_tlast    // done_res
);

  logic         in_valid;
  logic [7:0]   in_char;
  logic         in_last;
  logic         advance;
  logic         has_result;
  b64d_result_t result;
  b64d_result_t held;

  b64d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .char_code (in_char),
    .last_char (in_last),
    .has_result(has_result),
    .result    (result)
  );

  assign advance = in_valid && (!m_tvalid || m_tready || !has_result);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  b64d_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && has_result),
    .load_result(result),
    .tready     (m_tready),
    .tvalid     (m_tvalid),
    .held       (held)
  );

  assign m_tdata = {held.byte_count, held.data_byte};
  assign m_tuser = {held.empty_res, held.byte_valid};
  assign m_tlast = held.done_res;

endmodule

// ===== tb/base64_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Self-checking testbench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// Characters are sent one per transaction, and an in-bench decoder predicts
// every output transaction. Short directed texts cover the alphabet
// extremes, both alphabets, skipped characters, the pad stop and texts that
// yield no bytes. Random texts follow: mostly well-formed base64 with
// padding and stray whitespace, plus texts of arbitrary bytes. Both sides
// stall at random in several phases, and in some texts the sender waits for
// all outstanding output in the middle of the text.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb import b64d_pkg::*;;

  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  logic [11:0]           acc_bits = '0;
  logic [2:0]            acc_pending = '0;
  logic                  pad_seen = 1'b0;
  logic [COUNT_BITS-1:0] bytes_out = '0;

  b64d_result_t byte_results_due[$];
  b64d_result_t got_res;
  b64d_result_t want_res;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned chars_sent = 0;
  int unsigned mismatches = 0;

  base64_stream_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Returns {valid, value} for one character of either alphabet.
  function automatic logic [6:0] sextet_value(input logic [7:0] ch);
    if (ch >= 8'h41 && ch <= 8'h5A) return {1'b1, 6'(ch - 8'h41)};
    if (ch >= 8'h61 && ch <= 8'h7A) return {1'b1, 6'(ch - 8'h61 + 8'd26)};
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, 6'(ch - 8'h30 + 8'd52)};
    if (ch == 8'h2B || ch == 8'h2D) return {1'b1, 6'd62};
    if (ch == 8'h2F || ch == 8'h5F) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  task automatic decode_char(input logic [7:0] ch, input logic lst);
    b64d_result_t r;
    logic [6:0]   sx;
    logic         have;
    int unsigned  bits;
    r = '0;
    have = 1'b0;
    if (!pad_seen) begin
      if (ch == PAD_CHAR) begin
        pad_seen = 1'b1;
      end else begin
        sx = sextet_value(ch);
        if (sx[6]) begin
          acc_bits = {acc_bits[5:0], sx[5:0]};
          bits = acc_pending + 6;
          if (bits >= 8) begin
            bits = bits - 8;
            r.data_byte = 8'(acc_bits >> bits);
            r.byte_valid = 1'b1;
            have = 1'b1;
            if (bytes_out != '1) bytes_out = bytes_out + COUNT_BITS'(1);
          end
          acc_pending = 3'(bits);
        end
      end
    end
    if (lst) begin
      r.done_res = 1'b1;
      r.empty_res = (bytes_out == '0);
      r.byte_count = bytes_out;
      acc_bits = '0;
      acc_pending = '0;
      pad_seen = 1'b0;
      bytes_out = '0;
    end
    if (have || lst) byte_results_due.push_back(r);
  endtask

  task automatic note_mismatch(input string what, input b64d_result_t want,
                               input b64d_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte=%02h valid=%0b done=%0b empty=%0b count=%0d",
               $realtime, what, want.data_byte, want.byte_valid, want.done_res,
               want.empty_res, want.byte_count);
      $display("%0t: %s: actual   byte=%02h valid=%0b done=%0b empty=%0b count=%0d",
               $realtime, what, got.data_byte, got.byte_valid, got.done_res,
               got.empty_res, got.byte_count);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.data_byte = m_tdata[7:0];
      got_res.byte_count = m_tdata[31:8];
      got_res.byte_valid = m_tuser[0];
      got_res.empty_res = m_tuser[1];
      got_res.done_res = m_tlast;
      if (byte_results_due.size() == 0) begin
        note_mismatch("unexpected transaction", '0, got_res);
      end else begin
        want_res = byte_results_due.pop_front();
        if (got_res !== want_res) note_mismatch("wrong result", want_res, got_res);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL base64_stream_decoder");
    $finish;
  end

  task automatic send_char(input logic [7:0] ch, input logic lst);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tlast <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
    decode_char(ch, lst);
  endtask

  task automatic send_text(input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (byte_results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_symbol();
    int unsigned k;
    k = $urandom_range(63);
    if (k < 26) return 8'(8'h41 + k);
    if (k < 52) return 8'(8'h61 + k - 26);
    if (k < 62) return 8'(8'h30 + k - 52);
    if (k == 62) return $urandom_range(1) ? 8'h2B : 8'h2D;
    return $urandom_range(1) ? 8'h2F : 8'h5F;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(4))
      0: return 8'h0A;
      1: return 8'h0D;
      2: return 8'h20;
      3: return 8'h09;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // This covers both alphabets, skipped characters, the pad stop and texts with no bytes.
  task automatic test_alphabet_edges();
    logic [7:0] text[$];
    text = {8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h2B, 8'h2F, 8'h2D, 8'h5F,
            8'h0A, 8'h20, 8'h00, 8'hFF, 8'h80, 8'h7F, PAD_CHAR, 8'h51, 8'hFF};
    send_text(text);
    text = {8'h41};
    send_text(text);
    text = {PAD_CHAR};
    send_text(text);
    text = {8'h51, 8'h55};
    send_text(text);
  endtask

  task automatic test_random_texts(input int unsigned n_chars);
    logic [7:0]  text[$];
    int unsigned start;
    int unsigned body_len;
    int unsigned pads;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      text.delete();
      body_len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(1, 16);
      for (int i = 0; i < body_len; i++) begin
        if ($urandom_range(11) == 0) text.push_back(noise_char());
        text.push_back(random_symbol());
      end
      pads = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 2);
      repeat (pads) text.push_back(PAD_CHAR);
      if (pads != 0 && $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(255)));
      end
      if (text.size() == 0) text.push_back(random_symbol());
      send_text(text);
    end
  endtask

  task automatic test_garbage_texts(input int unsigned n_chars);
    logic [7:0]  text[$];
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      text.delete();
      repeat ($urandom_range(1, 16)) text.push_back(8'($urandom_range(255)));
      send_text(text);
    end
  endtask

  // The sender stops mid-text until all outstanding output has drained.
  task automatic test_pause_drain();
    logic [7:0]  text[$];
    int unsigned split;
    repeat (6) begin
      text.delete();
      repeat ($urandom_range(4, 20)) text.push_back(random_symbol());
      split = $urandom_range(1, text.size() - 1);
      for (int i = 0; i < split; i++) send_char(text[i], 1'b0);
      wait_drained();
      for (int i = split; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_alphabet_edges();

    set_idling(0, 0);
    test_random_texts(340);
    test_garbage_texts(70);

    set_idling(51, 0);
    test_random_texts(340);
    test_garbage_texts(70);

    set_idling(0, 51);
    test_random_texts(340);
    test_garbage_texts(70);

    set_idling(16, 16);
    test_random_texts(340);
    test_garbage_texts(70);
    test_pause_drain();

    wait_drained();
    repeat (10) @(posedge clk);
    mismatches += byte_results_due.size();
    if (mismatches == 0) begin
      $display("PASS base64_stream_decoder");
    end else begin
      $display("FAIL base64_stream_decoder");
    end
    $finish;
  end

endmodule

// ===== base64_stream_decoder.f =====
rtl/b64d_pkg.sv
rtl/b64d_core.sv
rtl/b64d_out_reg.sv
rtl/base64_stream_decoder.sv
tb/base64_stream_decoder_tb.sv
